[design/plt_pkg.sv]
// Shared types and codes for the positional list table.
// Holds the request and result item structs, op and status codes, capacity default.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package plt_pkg;

    localparam int PLT_CAPACITY = 64;

    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_DELETE  = 3'd1;
    localparam logic [2:0] OP_REPLACE = 3'd2;
    localparam logic [2:0] OP_READ    = 3'd3;
    localparam logic [2:0] OP_FIND    = 3'd4;
    localparam logic [2:0] OP_CLEAR   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    typedef struct packed {
        logic [2:0]         op;
        logic [6:0]         position;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic [5:0]         found_position;
        logic [6:0]         count;
        logic               empty_res;
    } t_res;

endpackage

`default_nettype wire

[design/plt_ram.sv]
// Element store: one write port and one read port, registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module plt_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [31:0]   i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic [31:0]        o_rd_data
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/plt_seq.sv]
// Request sequencer: range checks, shift walks, search walk and element count.
// Depends on plt_pkg and plt_ram.
`timescale 1ns / 1ps
`default_nettype none

module plt_seq #(
    parameter int CAPACITY = plt_pkg::PLT_CAPACITY
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire plt_pkg::t_req i_req,
    output logic               o_idle,
    output logic               o_done,
    output plt_pkg::t_res      o_res,
    input  wire logic          i_ack
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 7) ? CW : 7;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_DEL  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_FIND = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_pend, n_pend;
    logic          r_pfirst, n_pfirst;
    logic [AW-1:0] r_pdest, n_pdest;
    logic [PW-1:0] r_pos, n_pos;
    logic [31:0]   r_val, n_val;
    logic [1:0]    r_status, n_status;
    logic [31:0]   r_data, n_data;
    logic [AW-1:0] r_fpos, n_fpos;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;
    logic [PW-1:0] req_pos;
    logic [PW-1:0] cnt_x;

    plt_ram #(
        .DEPTH(CAPACITY),
        .AW   (AW)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    assign req_pos = PW'(i_req.position);
    assign cnt_x   = PW'(r_count);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_pfirst = r_pfirst;
        n_pdest  = r_pdest;
        n_pos    = r_pos;
        n_val    = r_val;
        n_status = r_status;
        n_data   = r_data;
        n_fpos   = r_fpos;
        wr_en    = 1'b0;
        wr_addr  = r_pdest;
        wr_data  = rd_data;
        rd_en    = 1'b0;
        rd_addr  = AW'(r_idx);

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_pos    = req_pos;
                    n_val    = i_req.value;
                    n_status = plt_pkg::ST_OK;
                    n_data   = '0;
                    n_fpos   = '0;
                    n_pend   = 1'b0;
                    n_pfirst = 1'b0;
                    n_state  = S_DONE;
                    case (i_req.op)
                        plt_pkg::OP_INSERT: begin
                            if (req_pos > cnt_x) begin
                                n_status = plt_pkg::ST_RANGE;
                            end else if (cnt_x == PW'(CAPACITY)) begin
                                n_status = plt_pkg::ST_FULL;
                            end else begin
                                n_idx   = r_count;
                                n_state = S_INS;
                            end
                        end
                        plt_pkg::OP_DELETE: begin
                            if (req_pos >= cnt_x) begin
                                n_status = plt_pkg::ST_RANGE;
                            end else begin
                                n_idx   = CW'(req_pos);
                                n_state = S_DEL;
                            end
                        end
                        plt_pkg::OP_REPLACE: begin
                            if (req_pos >= cnt_x) begin
                                n_status = plt_pkg::ST_RANGE;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = AW'(req_pos);
                                wr_data = i_req.value;
                            end
                        end
                        plt_pkg::OP_READ: begin
                            if (req_pos >= cnt_x) begin
                                n_status = plt_pkg::ST_RANGE;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = AW'(req_pos);
                                n_state = S_RD;
                            end
                        end
                        plt_pkg::OP_FIND: begin
                            n_idx   = '0;
                            n_state = S_FIND;
                        end
                        plt_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_status = plt_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_INS: begin
                wr_en = r_pend;
                if (PW'(r_idx) > r_pos) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_idx - 1'b1);
                    n_pend  = 1'b1;
                    n_pdest = AW'(r_idx);
                    n_idx   = r_idx - 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(r_pos);
                        wr_data = r_val;
                        n_count = r_count + 1'b1;
                        n_state = S_DONE;
                    end
                end
            end
            S_DEL: begin
                if (r_pend) begin
                    if (r_pfirst) begin
                        n_data = rd_data;
                    end else begin
                        wr_en = 1'b1;
                    end
                end
                if (r_idx < r_count) begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'(r_idx);
                    n_pend   = 1'b1;
                    n_pfirst = (PW'(r_idx) == r_pos);
                    n_pdest  = AW'(r_idx - 1'b1);
                    n_idx    = r_idx + 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count = r_count - 1'b1;
                        n_state = S_DONE;
                    end
                end
            end
            S_RD: begin
                n_data  = rd_data;
                n_state = S_DONE;
            end
            S_FIND: begin
                if (r_pend && (rd_data == r_val)) begin
                    n_fpos  = r_pdest;
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                end else if (r_idx < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_idx);
                    n_pend  = 1'b1;
                    n_pdest = AW'(r_idx);
                    n_idx   = r_idx + 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_status = plt_pkg::ST_MISS;
                        n_state  = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
        r_idx    <= n_idx;
        r_pfirst <= n_pfirst;
        r_pdest  <= n_pdest;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_status <= n_status;
        r_data   <= n_data;
        r_fpos   <= n_fpos;
    end

    assign o_idle               = (r_state == S_IDLE);
    assign o_done               = (r_state == S_DONE);
    assign o_res.status         = r_status;
    assign o_res.data           = r_data;
    assign o_res.found_position = 6'(r_fpos);
    assign o_res.count          = 7'(r_count);
    assign o_res.empty_res      = (r_count == '0);

endmodule

`default_nettype wire

[design/positional_list_table.sv]
// Top level of the positional list table: input handshake and output result register.
// Depends on plt_pkg and plt_seq.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------
//  request | in        | i_in_valid / o_in_ready    | i_in_item  (t_req)
//  result  | out       | o_out_valid / i_out_ready  | o_out_item (t_res)
//
// One item at a time, one store entry per cycle: insert shifts entries up from the tail to
// the position, delete shifts those after it down, find scans from the head to a match;
// read, replace, clear, unknown ops and rejected items need no walk. Results are registered.
// Reset clears the count at once; the store needs no clearing pass.
// A new item is taken while the previous result waits in the output register;
// its result then holds in the sequencer until the register frees up.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_table #(
    parameter int CAPACITY = plt_pkg::PLT_CAPACITY
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire plt_pkg::t_req i_in_item,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output plt_pkg::t_res      o_out_item
);

    logic          seq_idle;
    logic          seq_done;
    logic          seq_ack;
    plt_pkg::t_res seq_res;
    logic          r_out_valid, n_out_valid;
    plt_pkg::t_res r_out_item;

    plt_seq #(
        .CAPACITY(CAPACITY)
    ) u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_in_valid && seq_idle),
        .i_req  (i_in_item),
        .o_idle (seq_idle),
        .o_done (seq_done),
        .o_res  (seq_res),
        .i_ack  (seq_ack)
    );

    assign seq_ack = seq_done && (!r_out_valid || i_out_ready);

    always_comb begin
        n_out_valid = r_out_valid;
        if (seq_ack) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (seq_ack) begin
            r_out_item <= seq_res;
        end
    end

    assign o_in_ready  = seq_idle;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for positional_list_table: a queued request driver, a result
// monitor with random stalls and one long hold, and an in-bench list predictor.
// Depends on plt_pkg and the positional_list_table RTL.

module tb_top;
    import plt_pkg::*;

    localparam int TAIL_ITEMS  = 50;
    localparam int PRESSURE_AT = 300;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 80;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_req in_item   = '0;
    logic out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_res o_out_item;

    t_req pend_q[$];
    t_res due_results[$];

    logic signed [31:0] list_mem [PLT_CAPACITY];
    int unsigned list_len = 0;
    int unsigned peak_len = 0;

    int unsigned plan_len = 0;
    logic signed [31:0] key_pool [8];

    int n_planned  = 0;
    int n_accepted = 0;
    int n_results  = 0;
    int n_errors   = 0;
    int send_gap   = 0;
    int recv_stall = 0;
    int long_hold  = 0;
    bit pressure_done = 1'b0;
    t_res want_r;

    positional_list_table u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic t_res list_op_result(t_req r);
        t_res res;
        int unsigned i;
        logic hit;
        res = '0;
        hit = 1'b0;
        res.status = ST_OK;
        case (r.op)
            OP_INSERT: begin
                if (r.position > list_len) begin
                    res.status = ST_RANGE;
                end else if (list_len >= PLT_CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = list_len; i > r.position; i--)
                        list_mem[i] = list_mem[i - 1];
                    list_mem[r.position] = r.value;
                    list_len++;
                end
            end
            OP_DELETE: begin
                if (r.position >= list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    res.data = list_mem[r.position];
                    for (i = r.position; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                end
            end
            OP_REPLACE: begin
                if (r.position >= list_len)
                    res.status = ST_RANGE;
                else
                    list_mem[r.position] = r.value;
            end
            OP_READ: begin
                if (r.position >= list_len)
                    res.status = ST_RANGE;
                else
                    res.data = list_mem[r.position];
            end
            OP_FIND: begin
                for (i = 0; i < list_len && !hit; i++) begin
                    if (list_mem[i] == r.value) begin
                        hit = 1'b1;
                        res.found_position = i[5:0];
                    end
                end
                if (!hit)
                    res.status = ST_MISS;
            end
            OP_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        if (list_len > peak_len)
            peak_len = list_len;
        res.count = list_len[6:0];
        res.empty_res = (list_len == 0);
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result %0d: %s got 0x%0h want 0x%0h", n_results, field, got,
                 want);
        n_errors++;
    endtask

    task automatic plan(logic [2:0] op, logic [6:0] pos, logic signed [31:0] val);
        t_req r;
        r.op = op;
        r.position = pos;
        r.value = val;
        pend_q.push_back(r);
        case (op)
            OP_INSERT: if (pos <= plan_len && plan_len < PLT_CAPACITY) plan_len++;
            OP_DELETE: if (pos < plan_len) plan_len--;
            OP_CLEAR:  plan_len = 0;
            default: begin
            end
        endcase
    endtask

    function automatic logic signed [31:0] pick_value(int pool_pct);
        if ($urandom_range(0, 99) < pool_pct)
            return key_pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    function automatic logic [6:0] pick_position(logic [2:0] op);
        if ($urandom_range(0, 99) < 15 || (op != OP_INSERT && plan_len == 0))
            return 7'($urandom_range(0, 127));
        if (op == OP_INSERT)
            return 7'($urandom_range(0, plan_len));
        return 7'($urandom_range(0, plan_len - 1));
    endfunction

    task automatic plan_random(int mode);
        int r;
        int ins_w;
        int del_w;
        logic [2:0] op;
        r = $urandom_range(0, 99);
        ins_w = (mode == 0) ? 55 : (mode == 1) ? 25 : 10;
        del_w = (mode == 0) ? 10 : (mode == 1) ? 25 : 55;
        if (r < ins_w)
            op = OP_INSERT;
        else if (r < ins_w + del_w)
            op = OP_DELETE;
        else if (r < ins_w + del_w + 10)
            op = OP_REPLACE;
        else if (r < ins_w + del_w + 20)
            op = OP_READ;
        else if (r < 97)
            op = OP_FIND;
        else if (r < 98)
            op = OP_CLEAR;
        else
            op = 3'($urandom_range(6, 7));
        plan(op, pick_position(op), pick_value(op == OP_FIND ? 70 : 40));
    endtask

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                due_results.push_back(list_op_result(in_item));
                n_accepted++;
            end
            if (!in_valid || o_in_ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pend_q.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 4);
                    in_valid <= 1'b0;
                end else if (pend_q.size() != 0) begin
                    in_item <= pend_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected item", 32'(o_out_item), 32'd0);
                end else begin
                    want_r = due_results.pop_front();
                    if (o_out_item.status !== want_r.status)
                        report_mismatch("status", 32'(o_out_item.status), 32'(want_r.status));
                    if (o_out_item.data !== want_r.data)
                        report_mismatch("data", o_out_item.data, want_r.data);
                    if (o_out_item.found_position !== want_r.found_position)
                        report_mismatch("found_position", 32'(o_out_item.found_position),
                                        32'(want_r.found_position));
                    if (o_out_item.count !== want_r.count)
                        report_mismatch("count", 32'(o_out_item.count), 32'(want_r.count));
                    if (o_out_item.empty_res !== want_r.empty_res)
                        report_mismatch("empty_res", 32'(o_out_item.empty_res),
                                        32'(want_r.empty_res));
                end
                n_results++;
            end
            if (long_hold != 0) begin
                long_hold--;
                out_ready <= 1'b0;
            end else if (!pressure_done && n_results >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                long_hold = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end else if (recv_stall != 0) begin
                recv_stall--;
                out_ready <= 1'b0;
            end else if (n_results + TAIL_ITEMS < n_planned && $urandom_range(0, 5) == 0) begin
                recv_stall = $urandom_range(0, 4);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        key_pool[0] = 32'sh0000_0000;
        key_pool[1] = -32'sd1;
        key_pool[2] = 32'sh7fff_ffff;
        key_pool[3] = 32'sh8000_0000;
        key_pool[4] = 32'sd1;
        key_pool[5] = 32'sh5555_5555;
        key_pool[6] = 32'shaaaa_aaaa;
        key_pool[7] = 32'sd7;

        // empty list corner cases
        plan(OP_READ, 7'd0, 32'sd0);
        plan(OP_DELETE, 7'd0, 32'sd0);
        plan(OP_REPLACE, 7'd0, 32'sd5);
        plan(OP_FIND, 7'd0, 32'sd0);
        plan(OP_INSERT, 7'd1, 32'sd9);
        plan(OP_INSERT, 7'd0, 32'sh7fff_ffff);
        plan(OP_INSERT, 7'd1, 32'sh8000_0000);
        plan(OP_INSERT, 7'd0, -32'sd1);
        plan(OP_INSERT, 7'd3, 32'sd0);
        plan(OP_READ, 7'd0, 32'sd0);
        plan(OP_READ, 7'd3, 32'sd0);
        plan(OP_READ, 7'd4, 32'sd0);
        plan(OP_READ, 7'd127, 32'sd0);
        plan(OP_REPLACE, 7'd2, 32'sh5555_5555);
        plan(OP_FIND, 7'd0, 32'sh5555_5555);
        plan(OP_FIND, 7'd0, 32'sd12345);
        plan(OP_DELETE, 7'd0, 32'sd0);
        plan(OP_DELETE, 7'd2, 32'sd0);
        plan(OP_DELETE, 7'd2, 32'sd0);
        plan(3'd6, 7'd0, 32'sd1);
        plan(3'd7, 7'd127, -32'sd1);
        plan(OP_CLEAR, 7'd0, 32'sd0);
        plan(OP_READ, 7'd0, 32'sd0);

        // fill to capacity, then push against the limit
        while (plan_len < PLT_CAPACITY)
            plan(OP_INSERT, 7'($urandom_range(0, plan_len)), pick_value(40));
        plan(OP_INSERT, 7'd0, 32'sd3);
        plan(OP_INSERT, 7'd64, 32'sd3);
        plan(OP_INSERT, 7'd65, 32'sd3);
        plan(OP_READ, 7'd63, 32'sd0);
        plan(OP_READ, 7'd64, 32'sd0);
        plan(OP_FIND, 7'd0, key_pool[$urandom_range(0, 7)]);

        for (int k = 0; k < 520; k++)
            plan_random((k / 80) % 3);
        n_planned = pend_q.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (n_accepted != n_planned) @(posedge clk);
        while (due_results.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d requests and %0d results, peak list length %0d of %0d",
                 n_accepted, n_results, peak_len, PLT_CAPACITY);
        $display("long output hold applied: %0d, mismatches: %0d", pressure_done, n_errors);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("timeout with %0d results still due", due_results.size());
        $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
design/plt_pkg.sv
design/plt_ram.sv
design/plt_seq.sv
design/positional_list_table.sv
sim/tb_top.sv
